FILE: design/bpa_pkg.sv
`default_nettype none
package bpa_pkg;

  localparam int PAGE_COUNT_DEF = 65536;
  localparam int NUM_ORDERS_DEF = 16;
  localparam int PAGE_SHIFT     = 12;
  localparam int ORD_W          = 5;
  localparam logic [ORD_W-1:0] NOT_FREE = 5'd31;
  localparam logic [63:0] BASE_RESET = 64'hFFFF_8000_0000_0000;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ORDER = 2'd1,
    ST_NO_BLOCK  = 2'd2,
    ST_BAD_ADDR  = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_CLR, S_BORD, S_BPUSH, S_IDLE, S_DECODE, S_ASRCH, S_APOP, S_APOPW,
    S_PUSHLO, S_PUSHHI, S_FCHK, S_FLOOP, S_FPO, S_WCHK, S_WNEXT, S_WUNLINK,
    S_FPUSH, S_RES_ALLOC, S_RES_FREE, S_RES_ERR
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLR, OP_BORD, OP_BPUSH, OP_ACCEPT, OP_SRCH, OP_POP,
    OP_POP_BREAK, OP_POP_SPLIT, OP_POP_LAST, OP_PUSH_LO, OP_PUSH_HI,
    OP_FSETUP, OP_RD_PO, OP_WSTART, OP_WSTEP, OP_WLOAD, OP_RDLB, OP_UNLINK,
    OP_PUSH_PAGE, OP_RES_ALLOC, OP_RES_FREE, OP_RES_ERR
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t err;
  } cmd_t;

  typedef struct packed {
    logic ord_ok;
    logic is_free;
    logic addr_bad;
    logic idx_top;
    logic head_zero;
    logic idx_eq_req;
    logic merge_top;
    logic buddy_out;
    logic po_match;
    logic walk_fail;
    logic walk_hit;
    logic out_full;
    logic clr_last;
    logic build_last;
  } stat_t;

endpackage
`default_nettype wire

FILE: design/bpa_dpath.sv
`default_nettype none
module bpa_dpath #(
  parameter int PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF,
  parameter int NUM_ORDERS = bpa_pkg::NUM_ORDERS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  input  logic [63:0]               cfg_region_base,
  input  logic                      in_req_type,
  input  logic [4:0]                in_req_order,
  input  logic [63:0]               in_free_address,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [63:0]               out_block_address,
  output logic [15:0]               out_block_page,
  output logic [3:0]                out_final_order,
  input  bpa_pkg::cmd_t             cmd,
  output bpa_pkg::stat_t            stat
);
  import bpa_pkg::*;

  localparam int PW  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int LW  = $clog2(PAGE_COUNT + 1);
  localparam int OIW = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
  localparam int HW  = ((PW > NUM_ORDERS) ? PW : NUM_ORDERS) + 1;

  logic [ORD_W-1:0] po_mem [PAGE_COUNT];
  logic [LW-1:0]    link_mem [PAGE_COUNT];
  logic [LW-1:0]    head_r [NUM_ORDERS];

  logic [63:0]      base_r, addr_r;
  logic             type_r;
  logic [ORD_W-1:0] rord_r, idx_r, po_rd_r;
  logic [PW-1:0]    blk_r, page_r, prev_r, bcur_r, clr_r;
  logic [LW-1:0]    cur_r, steps_r, rem_r, link_rd_r;
  logic             has_prev_r;

  logic             out_valid_r;
  status_t          out_status_r;
  logic [63:0]      out_addr_r;
  logic [15:0]      out_page_r;
  logic [3:0]       out_ord_r;

  logic [LW-1:0]    head_cur, hm1, cm1;
  logic [PW-1:0]    head_pg, cur_pg, hi_pg, buddy_pg;
  logic [HW-1:0]    ostep, hi_w, buddy_w;
  logic             hi_ok, buddy_ok, addr_bad, out_full, res_ld;
  logic [63:0]      off;
  logic [ORD_W-1:0] hb, bord;

  logic             po_we, link_we, head_we;
  logic [PW-1:0]    po_wa, link_wa, po_ra, link_ra;
  logic [ORD_W-1:0] po_wd;
  logic [LW-1:0]    link_wd, head_wd;

  assign head_cur = (idx_r < ORD_W'(NUM_ORDERS)) ? head_r[idx_r[OIW-1:0]] : '0;
  assign hm1      = head_cur - LW'(1);
  assign head_pg  = hm1[PW-1:0];
  assign cm1      = cur_r - LW'(1);
  assign cur_pg   = cm1[PW-1:0];
  assign ostep    = HW'(1) << idx_r;
  assign hi_w     = HW'(blk_r) + ostep;
  assign hi_ok    = hi_w < HW'(PAGE_COUNT);
  assign hi_pg    = hi_w[PW-1:0];
  assign buddy_w  = HW'(page_r) ^ ostep;
  assign buddy_ok = buddy_w < HW'(PAGE_COUNT);
  assign buddy_pg = buddy_w[PW-1:0];
  assign off      = (addr_r - base_r) >> PAGE_SHIFT;
  assign addr_bad = (addr_r == 64'd0) || (off >= 64'(PAGE_COUNT));
  assign out_full = out_valid_r && out_stall;
  assign res_ld   = (cmd.op == OP_RES_ALLOC) || (cmd.op == OP_RES_FREE) ||
                    (cmd.op == OP_RES_ERR);

  // largest initial block that fits the remaining pages
  always_comb begin
    hb = '0;
    for (int i = 0; i < LW; i++) begin
      if (rem_r[i]) hb = ORD_W'(i);
    end
    bord = (hb > ORD_W'(NUM_ORDERS - 1)) ? ORD_W'(NUM_ORDERS - 1) : hb;
  end

  always_comb begin
    po_we   = 1'b0;
    po_wa   = page_r;
    po_wd   = NOT_FREE;
    po_ra   = buddy_pg;
    link_we = 1'b0;
    link_wa = page_r;
    link_wd = head_cur;
    link_ra = head_pg;
    head_we = 1'b0;
    head_wd = link_rd_r;
    case (cmd.op)
      OP_CLR: begin
        po_we = 1'b1;
        po_wa = clr_r;
      end
      OP_BPUSH: begin
        po_we   = 1'b1;
        po_wa   = bcur_r;
        po_wd   = idx_r;
        link_we = 1'b1;
        link_wa = bcur_r;
        head_we = 1'b1;
        head_wd = LW'(bcur_r) + LW'(1);
      end
      OP_POP: begin
        po_we   = 1'b1;
        po_wa   = head_pg;
        link_ra = head_pg;
      end
      OP_POP_SPLIT, OP_POP_LAST: head_we = 1'b1;
      OP_PUSH_LO: begin
        po_we   = 1'b1;
        po_wa   = blk_r;
        po_wd   = idx_r;
        link_we = 1'b1;
        link_wa = blk_r;
        head_we = 1'b1;
        head_wd = LW'(blk_r) + LW'(1);
      end
      OP_PUSH_HI: begin
        po_we   = hi_ok;
        po_wa   = hi_pg;
        po_wd   = idx_r;
        link_we = hi_ok;
        link_wa = hi_pg;
        head_we = hi_ok;
        head_wd = LW'(hi_pg) + LW'(1);
      end
      OP_WSTEP: link_ra = cur_pg;
      OP_RDLB:  link_ra = buddy_pg;
      OP_UNLINK: begin
        po_we   = 1'b1;
        po_wa   = buddy_pg;
        link_we = has_prev_r;
        link_wa = prev_r;
        link_wd = link_rd_r;
        head_we = !has_prev_r;
      end
      OP_PUSH_PAGE: begin
        po_we   = 1'b1;
        po_wd   = idx_r;
        link_we = 1'b1;
        head_we = 1'b1;
        head_wd = LW'(page_r) + LW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (po_we) po_mem[po_wa] <= po_wd;
    po_rd_r <= po_mem[po_ra];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    link_rd_r <= link_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ORDERS; i++) head_r[i] <= '0;
    end else if (head_we) begin
      head_r[idx_r[OIW-1:0]] <= head_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
    end else if (cfg_valid) begin
      base_r <= cfg_region_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      bcur_r <= '0;
      rem_r  <= LW'(PAGE_COUNT);
      idx_r  <= '0;
    end else begin
      case (cmd.op)
        OP_CLR:   clr_r <= clr_r + PW'(1);
        OP_BORD:  idx_r <= bord;
        OP_BPUSH: begin
          bcur_r <= PW'(HW'(bcur_r) + ostep);
          rem_r  <= rem_r - LW'(ostep);
        end
        OP_ACCEPT: begin
          type_r <= in_req_type;
          rord_r <= in_req_order;
          addr_r <= in_free_address;
          idx_r  <= in_req_order;
        end
        OP_SRCH:      idx_r <= idx_r + ORD_W'(1);
        OP_POP:       blk_r <= head_pg;
        OP_POP_BREAK: idx_r <= rord_r;
        OP_POP_SPLIT: idx_r <= idx_r - ORD_W'(1);
        OP_FSETUP:    page_r <= off[PW-1:0];
        OP_WSTART: begin
          cur_r      <= head_cur;
          has_prev_r <= 1'b0;
          steps_r    <= '0;
        end
        OP_WSTEP: begin
          prev_r     <= cur_pg;
          has_prev_r <= 1'b1;
          steps_r    <= steps_r + LW'(1);
        end
        OP_WLOAD: cur_r <= link_rd_r;
        OP_UNLINK: begin
          if (buddy_pg < page_r) page_r <= buddy_pg;
          idx_r <= idx_r + ORD_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_RES_ALLOC: begin
        out_status_r <= ST_OK;
        out_addr_r   <= base_r + (64'(blk_r) << PAGE_SHIFT);
        out_page_r   <= 16'(blk_r);
        out_ord_r    <= rord_r[3:0];
      end
      OP_RES_FREE: begin
        out_status_r <= ST_OK;
        out_addr_r   <= 64'd0;
        out_page_r   <= 16'(page_r);
        out_ord_r    <= idx_r[3:0];
      end
      OP_RES_ERR: begin
        out_status_r <= cmd.err;
        out_addr_r   <= 64'd0;
        out_page_r   <= 16'd0;
        out_ord_r    <= 4'd0;
      end
      default: ;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_address = out_addr_r;
  assign out_block_page    = out_page_r;
  assign out_final_order   = out_ord_r;

  always_comb begin
    stat.ord_ok     = rord_r < ORD_W'(NUM_ORDERS);
    stat.is_free    = type_r;
    stat.addr_bad   = addr_bad;
    stat.idx_top    = idx_r == ORD_W'(NUM_ORDERS);
    stat.head_zero  = head_cur == '0;
    stat.idx_eq_req = idx_r == rord_r;
    stat.merge_top  = idx_r >= ORD_W'(NUM_ORDERS - 1);
    stat.buddy_out  = !buddy_ok;
    stat.po_match   = po_rd_r == idx_r;
    stat.walk_fail  = (steps_r == LW'(PAGE_COUNT)) || (cur_r == '0);
    stat.walk_hit   = cur_pg == buddy_pg;
    stat.out_full   = out_full;
    stat.clr_last   = clr_r == PW'(PAGE_COUNT - 1);
    stat.build_last = rem_r == LW'(ostep);
  end

  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_ld |-> !out_full) else $error("result loaded over a waiting item");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_POP) |-> (head_cur != '0)) else $error("pop from empty list");
  a_head_idx: assert property (@(posedge clk) disable iff (!rst_n)
    head_we |-> (idx_r < ORD_W'(NUM_ORDERS))) else $error("list head index out of range");

endmodule
`default_nettype wire

FILE: design/bpa_ctrl.sv
`default_nettype none
module bpa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  bpa_pkg::stat_t stat,
  output bpa_pkg::cmd_t  cmd
);
  import bpa_pkg::*;

  state_t  state_r, state_nxt;
  status_t err_r, err_nxt;

  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    unique case (state_r)
      S_CLR:   if (stat.clr_last) state_nxt = S_BORD;
      S_BORD:  state_nxt = S_BPUSH;
      S_BPUSH: state_nxt = stat.build_last ? S_IDLE : S_BORD;
      S_IDLE:  if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        if (!stat.ord_ok) begin
          state_nxt = S_RES_ERR;
          err_nxt   = ST_BAD_ORDER;
        end else begin
          state_nxt = stat.is_free ? S_FCHK : S_ASRCH;
        end
      end
      S_ASRCH: begin
        if (stat.idx_top) begin
          state_nxt = S_RES_ERR;
          err_nxt   = ST_NO_BLOCK;
        end else if (!stat.head_zero) begin
          state_nxt = S_APOP;
        end
      end
      S_APOP: begin
        if (!stat.head_zero) begin
          state_nxt = S_APOPW;
        end else if (stat.idx_eq_req) begin
          state_nxt = S_RES_ERR;
          err_nxt   = ST_NO_BLOCK;
        end
      end
      S_APOPW:  state_nxt = stat.idx_eq_req ? S_RES_ALLOC : S_PUSHLO;
      S_PUSHLO: state_nxt = S_PUSHHI;
      S_PUSHHI: state_nxt = S_APOP;
      S_FCHK: begin
        if (stat.addr_bad) begin
          state_nxt = S_RES_ERR;
          err_nxt   = ST_BAD_ADDR;
        end else begin
          state_nxt = S_FLOOP;
        end
      end
      S_FLOOP:   state_nxt = (stat.merge_top || stat.buddy_out) ? S_FPUSH : S_FPO;
      S_FPO:     state_nxt = stat.po_match ? S_WCHK : S_FPUSH;
      S_WCHK: begin
        if (stat.walk_fail)     state_nxt = S_FPUSH;
        else if (stat.walk_hit) state_nxt = S_WUNLINK;
        else                    state_nxt = S_WNEXT;
      end
      S_WNEXT:   state_nxt = S_WCHK;
      S_WUNLINK: state_nxt = S_FLOOP;
      S_FPUSH:   state_nxt = S_RES_FREE;
      S_RES_ALLOC, S_RES_FREE, S_RES_ERR: if (!stat.out_full) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op  = OP_NONE;
    cmd.err = err_r;
    unique case (state_r)
      S_CLR:     cmd.op = OP_CLR;
      S_BORD:    cmd.op = OP_BORD;
      S_BPUSH:   cmd.op = OP_BPUSH;
      S_IDLE:    if (in_valid) cmd.op = OP_ACCEPT;
      S_DECODE:  cmd.op = OP_NONE;
      S_ASRCH:   if (!stat.idx_top && stat.head_zero) cmd.op = OP_SRCH;
      S_APOP: begin
        if (!stat.head_zero)      cmd.op = OP_POP;
        else if (!stat.idx_eq_req) cmd.op = OP_POP_BREAK;
      end
      S_APOPW:   cmd.op = stat.idx_eq_req ? OP_POP_LAST : OP_POP_SPLIT;
      S_PUSHLO:  cmd.op = OP_PUSH_LO;
      S_PUSHHI:  cmd.op = OP_PUSH_HI;
      S_FCHK:    if (!stat.addr_bad) cmd.op = OP_FSETUP;
      S_FLOOP:   if (!(stat.merge_top || stat.buddy_out)) cmd.op = OP_RD_PO;
      S_FPO:     if (stat.po_match) cmd.op = OP_WSTART;
      S_WCHK: begin
        if (stat.walk_fail)     cmd.op = OP_NONE;
        else if (stat.walk_hit) cmd.op = OP_RDLB;
        else                    cmd.op = OP_WSTEP;
      end
      S_WNEXT:     cmd.op = OP_WLOAD;
      S_WUNLINK:   cmd.op = OP_UNLINK;
      S_FPUSH:     cmd.op = OP_PUSH_PAGE;
      S_RES_ALLOC: if (!stat.out_full) cmd.op = OP_RES_ALLOC;
      S_RES_FREE:  if (!stat.out_full) cmd.op = OP_RES_FREE;
      S_RES_ERR:   if (!stat.out_full) cmd.op = OP_RES_ERR;
      default:     cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      err_r   <= ST_OK;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

endmodule
`default_nettype wire

FILE: design/buddy_page_allocator.sv
`default_nettype none
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  req_type, req_order, free_address
// out      output     out_valid/out_stall  status, block_address, block_page, final_order
// cfg      input      cfg_valid/cfg_ready  region_base
//
// One item at a time. Allocate: search upward from the requested order for a
// non-empty list, pop its head, push both halves one order down per split, and
// pop the final block. Free: check the address; per merge, read the buddy's
// page order, walk its list to the buddy and unlink it; then push the block
// (page order and link memories each give one registered access a cycle).
// Reset: a clearing pass over the page order memory, then a build pass that
// pushes each initial block; no item is taken meanwhile, cfg always is.
// A waiting result does not block the next item; a second result waits.
module buddy_page_allocator #(
  parameter int PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF,
  parameter int NUM_ORDERS = bpa_pkg::NUM_ORDERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_region_base,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [4:0]  in_req_order,
  input  logic [63:0] in_free_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [63:0] out_block_address,
  output logic [15:0] out_block_page,
  output logic [3:0]  out_final_order
);
  import bpa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // hold the base register open for writes at all times
  assign cfg_ready = 1'b1;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bpa_dpath #(
    .PAGE_COUNT (PAGE_COUNT),
    .NUM_ORDERS (NUM_ORDERS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_region_base   (cfg_region_base),
    .in_req_type       (in_req_type),
    .in_req_order      (in_req_order),
    .in_free_address   (in_free_address),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_block_address (out_block_address),
    .out_block_page    (out_block_page),
    .out_final_order   (out_final_order),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule
`default_nettype wire

FILE: sim/buddy_page_allocator_tb.sv
`default_nettype none
module buddy_page_allocator_tb;
  import bpa_pkg::*;

  localparam int NP        = PAGE_COUNT_DEF;
  localparam int NO        = NUM_ORDERS_DEF;
  localparam int LIMIT     = 20_000_000;
  localparam int SETTLE    = 200;
  localparam int RAND_ITEMS = 1500;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;
  localparam logic [16:0] LINK_END = 17'd0;

  typedef struct {
    logic        kind;
    logic [4:0]  ord;
    logic [63:0] addr;
  } req_item_t;

  typedef struct {
    status_t     st;
    logic [63:0] addr;
    logic [15:0] pg;
    logic [3:0]  ord;
  } alloc_result_t;

  typedef struct {
    int unsigned pg;
    int unsigned ord;
  } live_block_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_region_base = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type = 1'b0;
  logic [4:0]  in_req_order = '0;
  logic [63:0] in_free_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [63:0] out_block_address;
  logic [15:0] out_block_page;
  logic [3:0]  out_final_order;

  buddy_page_allocator uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_region_base(cfg_region_base),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_req_order(in_req_order), .in_free_address(in_free_address),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_block_address(out_block_address), .out_block_page(out_block_page),
    .out_final_order(out_final_order)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Allocator image: order per page, list links and heads; links and heads page+1 coded
  logic [4:0]    blk_order [NP];
  logic [16:0]   blk_link  [NP];
  logic [16:0]   free_head [NO];
  logic [63:0]   mirror_base;

  req_item_t     pending_reqs[$];
  alloc_result_t expected_results[$];
  live_block_t   live_blocks[$];
  int            errors = 0;
  int unsigned   cycles = 0;
  int            send_gap = 0;
  int            stall_left = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void push_free(int unsigned pg, int unsigned ord);
    if (pg >= NP || ord >= NO) return;
    blk_order[pg] = ord[4:0];
    blk_link[pg]  = free_head[ord];
    free_head[ord] = 17'(pg + 1);
  endfunction

  // Return -1 when the list has nothing usable
  function automatic int pop_free(int unsigned ord);
    int unsigned h;
    h = free_head[ord];
    if (h == 0 || h > NP) return -1;
    free_head[ord] = blk_link[h-1];
    blk_order[h-1] = NOT_FREE;
    return h - 1;
  endfunction

  function automatic bit unlink_free(int unsigned ord, int unsigned target);
    int unsigned cur;
    int          prev;
    cur  = free_head[ord];
    prev = -1;
    for (int unsigned n = 0; n < NP; n++) begin
      if (cur == 0 || cur > NP) return 0;
      if (cur - 1 == target) begin
        if (prev < 0) free_head[ord] = blk_link[target];
        else blk_link[prev] = blk_link[target];
        blk_order[target] = NOT_FREE;
        return 1;
      end
      prev = cur - 1;
      cur  = blk_link[prev];
    end
    return 0;
  endfunction

  function automatic void build_initial_blocks();
    int unsigned left, pos, ord;
    mirror_base = BASE_RESET;
    for (int i = 0; i < NP; i++) begin
      blk_order[i] = NOT_FREE;
      blk_link[i]  = LINK_END;
    end
    for (int i = 0; i < NO; i++) free_head[i] = LINK_END;
    left = NP;
    pos  = 0;
    while (left > 0) begin
      ord = NO - 1;
      while ((1 << ord) > left && ord > 0) ord--;
      push_free(pos, ord);
      pos  += 1 << ord;
      left -= 1 << ord;
    end
  endfunction

  // Work out the single result of one accepted request and update the image
  function automatic alloc_result_t serve_request(req_item_t r);
    alloc_result_t res;
    int unsigned   ord, cur, pg, buddy;
    int            blk;
    logic [63:0]   off;
    res = '{ST_OK, '0, '0, '0};
    ord = r.ord;
    if (ord >= NO) begin
      res.st = ST_BAD_ORDER;
      return res;
    end
    if (r.kind == REQ_ALLOC) begin
      cur = ord;
      while (cur < NO && free_head[cur] == LINK_END) cur++;
      if (cur >= NO) begin
        res.st = ST_NO_BLOCK;
        return res;
      end
      while (cur > ord) begin
        blk = pop_free(cur);
        if (blk < 0) break;
        cur--;
        push_free(blk, cur);
        push_free(blk + (1 << cur), cur);
      end
      blk = pop_free(ord);
      if (blk < 0) begin
        res.st = ST_NO_BLOCK;
        return res;
      end
      res.addr = mirror_base + (64'(blk) << PAGE_SHIFT);
      res.pg   = blk[15:0];
      res.ord  = ord[3:0];
      live_blocks.push_back('{blk, ord});
    end else begin
      off = (r.addr - mirror_base) >> PAGE_SHIFT;
      if (r.addr == 64'd0 || off >= 64'(NP)) begin
        res.st = ST_BAD_ADDR;
        return res;
      end
      pg = off[31:0];
      while (ord < NO - 1) begin
        buddy = pg ^ (1 << ord);
        if (buddy >= NP || blk_order[buddy] != ord[4:0]) break;
        if (!unlink_free(ord, buddy)) break;
        if (buddy < pg) pg = buddy;
        ord++;
      end
      push_free(pg, ord);
      res.pg  = pg[15:0];
      res.ord = ord[3:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
  endtask

  // Driver: launch the next item, hold it while stalled, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid)
        expected_results.push_back(serve_request('{in_req_type, in_req_order,
                                                   in_free_address}));
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req_item_t r;
        r = pending_reqs.pop_front();
        in_req_type     <= r.kind;
        in_req_order    <= r.ord;
        in_free_address <= r.addr;
        in_valid        <= 1'b1;
        send_gap        <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure, compare each accepted result in order
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, status", 64'(out_status), '0);
        end else begin
          alloc_result_t e;
          e = expected_results.pop_front();
          if (out_status !== e.st) report_mismatch("status", 64'(out_status), 64'(e.st));
          if (out_block_address !== e.addr)
            report_mismatch("block_address", out_block_address, e.addr);
          if (out_block_page !== e.pg)
            report_mismatch("block_page", 64'(out_block_page), 64'(e.pg));
          if (out_final_order !== e.ord)
            report_mismatch("final_order", 64'(out_final_order), 64'(e.ord));
        end
      end
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall  <= 1'b0;
        stall_left <= pick_gap();
      end
    end
  end

  // Watchdog: allows for the clearing pass after reset and long list walks
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("buddy_page_allocator test failed");
      $finish;
    end
  end

  task automatic queue_req(logic kind, logic [4:0] ord, logic [63:0] addr);
    while (pending_reqs.size() > 0) @(posedge clk);
    pending_reqs.push_back('{kind, ord, addr});
  endtask

  // Hold off until the block has nothing in flight; look between edges so
  // that the driver's updates of the edge have landed
  task automatic drain();
    do @(negedge clk);
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_base(logic [63:0] value);
    cfg_region_base <= value;
    cfg_valid       <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    mirror_base = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] page_addr(int unsigned pg);
    return mirror_base + (64'(pg) << PAGE_SHIFT);
  endfunction

  task automatic random_phase(int count);
    int r, k;
    live_block_t b;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        // well-formed traffic: free a live block or allocate a fresh one
        if (live_blocks.size() > 0 && $urandom_range(0, 99) < 30 + live_blocks.size()) begin
          k = $urandom_range(0, live_blocks.size() - 1);
          b = live_blocks[k];
          live_blocks.delete(k);
          queue_req(REQ_FREE, b.ord[4:0], page_addr(b.pg) + 64'($urandom_range(0, 4095)));
        end else begin
          k = $urandom_range(0, 99);
          if (k < 70)      k = $urandom_range(0, 3);
          else if (k < 95) k = $urandom_range(4, 9);
          else             k = $urandom_range(10, NO - 1);
          queue_req(REQ_ALLOC, k[4:0], {$urandom, $urandom});
        end
      end else if (r < 88) begin
        queue_req(1'($urandom), 5'($urandom_range(NO, 31)), {$urandom, $urandom});
      end else if (r < 96) begin
        // almost surely outside the region
        queue_req(REQ_FREE, 5'($urandom_range(0, NO - 1)), {$urandom, $urandom});
      end else begin
        queue_req(REQ_FREE, 5'($urandom_range(0, NO - 1)), 64'd0);
      end
      // sometimes pause until every outstanding result has come back
      if ($urandom_range(0, 199) == 0) drain();
    end
  endtask

  initial begin
    live_block_t b;
    build_initial_blocks();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: order extremes, empty lists, invalid orders and addresses
    queue_req(REQ_ALLOC, 5'd0, '0);
    queue_req(REQ_ALLOC, 5'd15, '0);
    queue_req(REQ_ALLOC, 5'd15, '1);
    queue_req(REQ_ALLOC, 5'd15, '0);
    queue_req(REQ_ALLOC, 5'd16, '0);
    queue_req(REQ_FREE, 5'd31, page_addr(0));
    queue_req(REQ_FREE, 5'd0, 64'd0);
    queue_req(REQ_FREE, 5'd0, page_addr(NP));
    queue_req(REQ_FREE, 5'd0, mirror_base - 64'd1);
    queue_req(REQ_FREE, 5'd3, '1);
    drain();
    // free one live block twice with offsets inside the page, then free the rest
    b = live_blocks.pop_front();
    queue_req(REQ_FREE, b.ord[4:0], page_addr(b.pg) + 64'hABC);
    queue_req(REQ_FREE, b.ord[4:0], page_addr(b.pg) + 64'hFFF);
    while (live_blocks.size() > 0) begin
      b = live_blocks.pop_front();
      queue_req(REQ_FREE, b.ord[4:0], page_addr(b.pg));
    end
    // misaligned free: page 1 released as an order-3 block
    queue_req(REQ_FREE, 5'd3, page_addr(1));
    queue_req(REQ_ALLOC, 5'd1, '0);
    queue_req(REQ_ALLOC, 5'd0, '0);
    drain();

    random_phase(RAND_ITEMS / 5);
    drain();
    write_base(64'd0);
    random_phase(RAND_ITEMS / 5);
    drain();
    write_base('1);
    random_phase(RAND_ITEMS / 5);
    drain();
    write_base({$urandom, $urandom});
    random_phase(RAND_ITEMS / 5);
    drain();
    write_base({$urandom, 20'($urandom), 12'd0});
    random_phase(RAND_ITEMS / 5);

    drain();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0)
      $display("buddy_page_allocator test passed");
    else
      $display("buddy_page_allocator test failed");
    $finish;
  end

endmodule
`default_nettype wire

FILE: buddy_page_allocator.f
design/bpa_pkg.sv
design/bpa_dpath.sv
design/bpa_ctrl.sv
design/buddy_page_allocator.sv
sim/buddy_page_allocator_tb.sv
